[rtl/pidw_pkg.sv]
`timescale 1ns / 1ps
package pidw_pkg;
    localparam int ERR_W   = 32;
    localparam int GAIN_W  = 24;
    localparam int TS_W    = 16;
    localparam int INTEG_W = 48;
    localparam int ACC_W   = 72;
    localparam int DIV_W   = 57;

    localparam logic [2:0] REG_PROP   = 3'd0;
    localparam logic [2:0] REG_INTEG  = 3'd1;
    localparam logic [2:0] REG_DERIV  = 3'd2;
    localparam logic [2:0] REG_OFFSET = 3'd3;
    localparam logic [2:0] REG_BOUND  = 3'd4;
    localparam logic [2:0] REG_GATE   = 3'd5;
    localparam logic [2:0] REG_ANGLE  = 3'd6;

    localparam logic signed [ERR_W:0] ANGLE_HALF = 33'sd11796480;
    localparam logic signed [ERR_W:0] ANGLE_FULL = 33'sd23592960;

    // Commands from the controller to the datapath.
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_WRAP   = 4'd2;
    localparam logic [3:0] OP_INTEG  = 4'd3;
    localparam logic [3:0] OP_LIMDIV = 4'd4;
    localparam logic [3:0] OP_CLAMP  = 4'd5;
    localparam logic [3:0] OP_DIFF   = 4'd6;
    localparam logic [3:0] OP_DDIV   = 4'd7;
    localparam logic [3:0] OP_PTERM  = 4'd8;
    localparam logic [3:0] OP_ITERM  = 4'd9;
    localparam logic [3:0] OP_SUM    = 4'd10;
    localparam logic [3:0] OP_CLEAR  = 4'd11;
    localparam logic [3:0] OP_DSTEP  = 4'd12;

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic wrap_done;
        logic div_done;
    } t_status;
endpackage

[rtl/pidw_datapath.sv]
`timescale 1ns / 1ps
module pidw_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pidw_pkg::t_cmd                  i_cmd,
    output pidw_pkg::t_status               o_status,
    input  logic [pidw_pkg::ERR_W-1:0]      i_error,
    input  logic [pidw_pkg::TS_W-1:0]       i_tstep,
    input  logic [pidw_pkg::GAIN_W-1:0]     i_kp,
    input  logic [pidw_pkg::GAIN_W-1:0]     i_ki,
    input  logic [pidw_pkg::GAIN_W-1:0]     i_kd,
    input  logic [pidw_pkg::ERR_W-1:0]      i_offset,
    input  logic [pidw_pkg::ERR_W-2:0]      i_bound,
    input  logic [pidw_pkg::ERR_W-2:0]      i_gate,
    input  logic                            i_angle,
    output logic [pidw_pkg::ERR_W-1:0]      o_drive,
    output logic                            o_held,
    output logic                            o_clamped
);
    import pidw_pkg::*;

    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_prev;
    logic                      r_phase;    // 0: ep, 1: diff
    logic signed [ERR_W:0]     r_ep;
    logic signed [ERR_W:0]     r_diff;
    logic signed [ERR_W-1:0]   r_e;
    logic [TS_W-1:0]           r_t;
    logic signed [ACC_W-1:0]   r_sum;
    logic                      r_held;
    logic                      r_clamped;
    // shared restoring divider
    logic [DIV_W-1:0]          r_quo;
    logic [DIV_W:0]            r_rem;
    logic [5:0]                r_cnt;
    logic                      r_neg;      // 1: divisor is the time step
    logic                      r_dsign;    // sign of the derivative numerator
    logic signed [ERR_W-1:0]   r_drive;

    logic signed [ERR_W:0]     w_ep;
    logic signed [ERR_W+TS_W+1:0] w_prod;
    logic signed [INTEG_W+1:0] w_inext;
    logic [ERR_W:0]            w_abs;
    logic [DIV_W:0]            w_rtry;
    logic [DIV_W:0]            w_sub;
    logic [DIV_W-1:0]          w_dnum;
    logic signed [ERR_W+GAIN_W+1:0] w_kdd;
    logic [ERR_W+GAIN_W:0]     w_kdabs;
    logic signed [ERR_W+GAIN_W+1:0] w_kpe;
    logic signed [ERR_W+GAIN_W:0]   w_kihi;   // ki times the integer part
    logic [GAIN_W+TS_W-1:0]    w_kilo;        // ki times the fraction bits
    logic [GAIN_W+TS_W:0]      w_kirnd;
    logic signed [DIV_W:0]     w_dterm;
    logic signed [ACC_W-1:0]   w_tot;

    assign w_ep   = $signed({i_error[ERR_W-1], i_error})
                  - $signed({i_offset[ERR_W-1], i_offset});
    assign w_abs  = r_ep[ERR_W] ? (ERR_W+1)'(0) - r_ep : r_ep;
    assign w_prod = r_ep * $signed({1'b0, r_t});
    assign w_inext = $signed({{2{r_integ[INTEG_W-1]}}, r_integ})
        + $signed(w_prod[ERR_W+TS_W+1:16]) + $signed({1'b0, w_prod[15]});
    assign w_kdd  = $signed({1'b0, i_kd}) * r_diff;
    assign w_kdabs = w_kdd[ERR_W+GAIN_W+1] ? (ERR_W+GAIN_W+1)'(-w_kdd)
                                           : w_kdd[ERR_W+GAIN_W:0];
    assign w_kpe  = $signed({1'b0, i_kp}) * r_ep;
    assign w_kihi = $signed({1'b0, i_ki}) * $signed(r_integ[INTEG_W-1:16]);
    assign w_kilo = i_ki * r_integ[15:0];
    assign w_kirnd = {1'b0, w_kilo} + (GAIN_W+TS_W+1)'(32768);
    assign w_rtry = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
    assign w_sub  = r_neg ? w_rtry - (DIV_W+1)'(r_t)
                          : w_rtry - (DIV_W+1)'(i_ki);
    assign w_dnum = (DIV_W)'(w_kdabs);
    // zero time step drives no derivative term
    assign w_dterm = (r_t == '0) ? $signed((DIV_W+1)'(0))
                   : (r_dsign ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo}));
    assign w_tot  = r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            unique case (i_cmd.op) inside
                OP_LOAD: begin
                    r_e       <= $signed(i_error);
                    r_t       <= i_tstep;
                    r_held    <= 1'b0;
                    r_clamped <= 1'b0;
                    r_phase   <= 1'b0;
                    r_ep      <= w_ep;
                end
                OP_WRAP: begin
                    // one turn per cycle
                    if (!i_angle) begin
                    end else if (r_ep > ANGLE_HALF) begin
                        r_ep <= r_ep - ANGLE_FULL;
                    end else if (r_ep < -ANGLE_HALF) begin
                        r_ep <= r_ep + ANGLE_FULL;
                    end
                end
                OP_INTEG: begin
                    if (i_gate != '0 && w_abs > {2'b0, i_gate}) begin
                        r_held <= 1'b1;
                    end else if (w_inext > $signed({3'b0, {(INTEG_W-1){1'b1}}})) begin
                        r_integ <= {1'b0, {(INTEG_W-1){1'b1}}};
                    end else if (w_inext < -$signed({2'b0, 1'b1, {(INTEG_W-1){1'b0}}})) begin
                        r_integ <= {1'b1, {(INTEG_W-1){1'b0}}};
                    end else begin
                        r_integ <= w_inext[INTEG_W-1:0];
                    end
                    r_neg <= 1'b0;
                    r_quo <= (DIV_W)'({i_bound, 16'b0});
                    r_rem <= '0;
                    r_cnt <= 6'(DIV_W);
                end
                OP_LIMDIV, OP_DDIV: begin
                    if (r_cnt != '0) begin
                        if (!w_sub[DIV_W]) begin
                            r_rem <= w_sub;
                            r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rtry;
                            r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                OP_CLAMP: begin
                    if (i_bound != '0 && i_ki != '0) begin
                        if (r_integ > $signed({1'b0, INTEG_W'(r_quo)})) begin
                            r_integ <= INTEG_W'(r_quo);
                            r_clamped <= 1'b1;
                        end else if ($signed({r_integ[INTEG_W-1], r_integ})
                                     < -$signed({1'b0, INTEG_W'(r_quo)})) begin
                            r_integ <= INTEG_W'(-$signed({1'b0, INTEG_W'(r_quo)}));
                            r_clamped <= 1'b1;
                        end
                    end
                    r_phase <= 1'b1;
                end
                OP_DIFF: begin
                    r_diff <= $signed({r_e[ERR_W-1], r_e}) - $signed({r_prev[ERR_W-1], r_prev});
                    r_prev <= r_e;
                end
                OP_DSTEP: begin
                    if (!i_angle) begin
                    end else if (r_diff > ANGLE_HALF) begin
                        r_diff <= r_diff - ANGLE_FULL;
                    end else if (r_diff < -ANGLE_HALF) begin
                        r_diff <= r_diff + ANGLE_FULL;
                    end
                    r_dsign <= w_kdd[ERR_W+GAIN_W+1];
                    r_quo   <= w_dnum;
                    r_rem   <= '0;
                    r_cnt   <= 6'(DIV_W);
                    r_neg   <= 1'b1;
                end
                OP_PTERM: begin
                    r_sum <= ACC_W'(w_dterm)
                           + ACC_W'($signed(w_kpe[ERR_W+GAIN_W+1:16]))
                           + ACC_W'($signed({1'b0, w_kpe[15]}));
                end
                OP_ITERM: begin
                    r_sum <= r_sum + ACC_W'(w_kihi)
                           + ACC_W'(w_kirnd[GAIN_W+TS_W:16]);
                end
                OP_SUM: begin
                    if (w_tot > $signed(ACC_W'(32'h7FFF_FFFF))) begin
                        r_drive <= 32'sh7FFF_FFFF;
                    end else if (w_tot < -$signed(ACC_W'(33'h0_8000_0000))) begin
                        r_drive <= 32'sh8000_0000;
                    end else begin
                        r_drive <= w_tot[ERR_W-1:0];
                    end
                end
                OP_CLEAR: begin
                    r_integ   <= '0;
                    r_prev    <= '0;
                    r_drive   <= '0;
                    r_held    <= 1'b0;
                    r_clamped <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.div_done  = (r_cnt == '0);
    assign o_status.wrap_done = !i_angle
        || (r_phase ? (r_diff <= ANGLE_HALF && r_diff >= -ANGLE_HALF)
                    : (r_ep <= ANGLE_HALF && r_ep >= -ANGLE_HALF));
    assign o_drive   = r_drive;
    assign o_held    = r_held;
    assign o_clamped = r_clamped;
endmodule

[rtl/pidw_ctrl.sv]
`timescale 1ns / 1ps
module pidw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_clear,
    input  logic               i_out_free,
    input  pidw_pkg::t_status  i_status,
    output pidw_pkg::t_cmd     o_cmd,
    output logic               o_busy,
    output logic               o_done
);
    import pidw_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_WRAP = 4'd1, S_INTEG = 4'd2,
        S_LIM = 4'd3, S_CLAMP = 4'd4, S_DIFF = 4'd5, S_DWRAP = 4'd6,
        S_DDIV = 4'd7, S_PT = 4'd8, S_IT = 4'd9, S_SUM = 4'd10, S_DONE = 4'd11,
        S_CLR = 4'd12, S_WAIT = 4'd13;

    logic [3:0] r_state, n_state;
    logic [1:0] r_cnt;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                o_cmd.op = i_clear ? OP_CLEAR : OP_LOAD;
                n_state  = i_clear ? S_CLR : S_WAIT;
            end
            S_WAIT:  begin o_cmd.op = OP_WRAP; n_state = S_WRAP; end
            S_WRAP:  begin
                o_cmd.op = OP_WRAP;
                if (i_status.wrap_done && r_cnt != 2'd0) n_state = S_INTEG;
            end
            S_INTEG: begin o_cmd.op = OP_INTEG; n_state = S_LIM; end
            S_LIM:   begin
                o_cmd.op = OP_LIMDIV;
                if (i_status.div_done) n_state = S_CLAMP;
            end
            S_CLAMP: begin o_cmd.op = OP_CLAMP; n_state = S_DIFF; end
            S_DIFF:  begin o_cmd.op = OP_DIFF; n_state = S_DWRAP; end
            S_DWRAP: begin
                o_cmd.op = OP_DSTEP;
                if (i_status.wrap_done && r_cnt != 2'd0) n_state = S_DDIV;
            end
            S_DDIV:  begin
                o_cmd.op = OP_DDIV;
                if (i_status.div_done) n_state = S_PT;
            end
            S_PT:    begin o_cmd.op = OP_PTERM; n_state = S_IT; end
            S_IT:    begin o_cmd.op = OP_ITERM; n_state = S_SUM; end
            S_SUM:   begin o_cmd.op = OP_SUM; n_state = S_DONE; end
            S_CLR:   n_state = S_DONE;
            S_DONE:  if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? 2'd0 : (r_cnt == 2'd3 ? r_cnt : r_cnt + 2'd1);
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE) && i_out_free;

    always_ff @(posedge i_clk) begin
        if (i_rst_n && r_state == S_IDLE && i_start)
            assert (!o_busy) else $error("start while busy");
    end
    ap_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_state == S_IDLE) else $error("done not followed by idle");
    ap_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> r_state != S_IDLE) else $error("start lost");
    ap_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |=> r_state == S_DONE) else $error("clear path");
endmodule

[rtl/pid_step_with_windup_and_angle_wrap.sv]
`timescale 1ns / 1ps
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: error_in[31:0], time_step[47:32]; tuser: command
// m_axis    out  tdata: drive[31:0]; tuser: integ_held, integ_clamped
// cfg       in   i_cfg_we, i_cfg_index, i_cfg_data
// A control step offers its result in the output register and takes the next
// transaction only once it is back in idle; the step runs two restoring divisions
// of 57 quotient bits on the shared divider (clamp limit, derivative).
// In angle mode the error and then the difference are wrapped one turn at a time
// until within half a turn. A clear command skips the step and goes to done.
// Reset is synchronous, active low.
// A finished result holds in the output register while the master side stalls.
module pid_step_with_windup_and_angle_wrap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // error_in, time_step
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // drive
    output logic [1:0]  m_axis_tuser,   // integ_held, integ_clamped
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import pidw_pkg::*;

    logic [GAIN_W-1:0] r_kp, r_ki, r_kd;
    logic [ERR_W-1:0]  r_offset;
    logic [ERR_W-2:0]  r_bound, r_gate;
    logic              r_angle;
    logic              r_mvalid;
    logic [31:0]       r_mdata;
    logic [1:0]        r_muser;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy, w_done, w_start, w_free;
    logic [ERR_W-1:0] w_drive;
    logic    w_held, w_clamped;

    assign s_axis_tready = !w_busy;
    assign w_start = s_axis_tvalid && s_axis_tready;
    assign w_free  = !r_mvalid || m_axis_tready;

    // hold registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0; r_ki <= '0; r_kd <= '0; r_offset <= '0;
            r_bound <= '0; r_gate <= '0; r_angle <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PROP:   r_kp     <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG:  r_ki     <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV:  r_kd     <= i_cfg_data[GAIN_W-1:0];
                REG_OFFSET: r_offset <= i_cfg_data;
                REG_BOUND:  r_bound  <= i_cfg_data[ERR_W-2:0];
                REG_GATE:   r_gate   <= i_cfg_data[ERR_W-2:0];
                REG_ANGLE:  r_angle  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    pidw_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_clear(s_axis_tuser),
        .i_out_free(w_free), .i_status(w_status), .o_cmd(w_cmd),
        .o_busy(w_busy), .o_done(w_done)
    );

    pidw_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_error(s_axis_tdata[31:0]), .i_tstep(s_axis_tdata[47:32]),
        .i_kp(r_kp), .i_ki(r_ki), .i_kd(r_kd), .i_offset(r_offset),
        .i_bound(r_bound), .i_gate(r_gate), .i_angle(r_angle),
        .o_drive(w_drive), .o_held(w_held), .o_clamped(w_clamped)
    );

    // output register: advance on done, drop on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_done) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_mdata <= w_drive;
            r_muser <= {w_clamped, w_held};
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;
endmodule
